>>> sv/qrls_pkg.sv
// shared constants, types and helpers of the QR linear solver
package qrls_pkg;

	localparam int MAX_ORDER   = 8;
	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int REQ_W       = 2;
	localparam int POS_W       = 3;
	localparam int ORD_W       = 4;
	localparam int ORDER_RESET = 8;
	localparam int IDX_W       = $clog2(MAX_ORDER);
	localparam int CNT_W       = $clog2(MAX_ORDER + 1);
	localparam int ADDR_W      = 2 * IDX_W;
	localparam int PROD_W      = 2 * DATA_W;
	localparam int PSH_W       = PROD_W - FRAC_BITS;
	localparam int ACC_W       = PSH_W + IDX_W + 1;
	localparam int DIV_W       = DATA_W + FRAC_BITS;
	localparam int DIVC_W      = $clog2(DIV_W + 1);
	localparam int SQ_W        = PROD_W;
	localparam int ROOT_STEPS  = SQ_W / 2;
	localparam int ROOTC_W     = $clog2(ROOT_STEPS + 1);

	localparam logic [REQ_W-1:0] REQ_WR_A  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_WR_B  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SOLVE = 2'd2;

	typedef enum logic [2:0] {
		OP_NONE, OP_LDV, OP_DOT_QV, OP_DOT_QB, OP_DOT_RX, OP_RES, OP_SQ
	} op_t;

	typedef enum logic [3:0] {
		ACT_NONE, ACT_LD_A, ACT_LD_B, ACT_START, ACT_CLR, ACT_LATCH_D, ACT_WR_R,
		ACT_WR_Y, ACT_SQRT, ACT_DIV_Q, ACT_DIV_X, ACT_WR_Q, ACT_WR_X
	} act_t;

	typedef struct packed {
		op_t              op;
		act_t             act;
		logic [IDX_W-1:0] vec;
		logic [IDX_W-1:0] idx;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic sqrt_busy;
		logic div_busy;
	} stat_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_GS_LD, ST_GS_KCHK, ST_GS_DOT, ST_GS_D, ST_GS_RES, ST_GS_SQ,
		ST_GS_SQRT, ST_GS_SQW, ST_GS_DIV, ST_GS_DIVW, ST_GS_WQ, ST_R_LD, ST_R_ROW,
		ST_R_DOT, ST_R_WR, ST_Y_ROW, ST_Y_DOT, ST_Y_WR, ST_B_ROW, ST_B_DOT,
		ST_B_DIV, ST_B_DIVW, ST_B_WX, ST_OUT, ST_DRAIN
	} state_t;

	function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if ((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1]))
			r = v[DATA_W-1:0];
		else if (v[ACC_W-1])
			r = {1'b1, {(DATA_W-1){1'b0}}};
		else
			r = {1'b0, {(DATA_W-1){1'b1}}};
		return r;
	endfunction

endpackage

>>> sv/qrls_if.sv
// request and result channel interfaces
interface qrls_req_if;
	logic                                valid;
	logic                                ready;
	logic [qrls_pkg::REQ_W-1:0]          req_type;
	logic [qrls_pkg::POS_W-1:0]          row;
	logic [qrls_pkg::POS_W-1:0]          col;
	logic signed [qrls_pkg::DATA_W-1:0]  value;
	modport source(output valid, req_type, row, col, value, input ready);
	modport sink(input valid, req_type, row, col, value, output ready);
endinterface

interface qrls_res_if;
	logic                                valid;
	logic                                ready;
	logic [qrls_pkg::POS_W-1:0]          x_index;
	logic signed [qrls_pkg::DATA_W-1:0]  x_value;
	logic                                singular;
	logic                                last;
	modport source(output valid, x_index, x_value, singular, last, input ready);
	modport sink(input valid, x_index, x_value, singular, last, output ready);
endinterface

>>> sv/qrls_div.sv
// restoring fixed-point divider, one quotient bit per cycle, saturated result
module qrls_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [qrls_pkg::DATA_W-1:0]  num,
	input  logic signed [qrls_pkg::DATA_W:0]    den,
	output logic                                busy,
	output logic signed [qrls_pkg::DATA_W-1:0]  quo
);
	import qrls_pkg::*;

	logic [DIVC_W-1:0] cnt_q;
	logic              neg_q;
	logic [DATA_W-1:0] dm_q;
	logic [DATA_W-1:0] rem_q;
	logic [DIV_W-1:0]  qd_q;
	logic [DATA_W:0]   rem_sh;
	logic              ge;
	logic [DATA_W-1:0] nm;
	logic [DATA_W:0]   dmag;

	assign nm     = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
	assign dmag   = den[DATA_W] ? (DATA_W+1)'(-den) : (DATA_W+1)'(den);
	assign rem_sh = {rem_q, qd_q[DIV_W-1]};
	assign ge     = rem_sh >= {1'b0, dm_q};
	assign busy   = cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIVC_W'(DIV_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[DATA_W-1] ^ den[DATA_W];
			dm_q  <= dmag[DATA_W-1:0];
			rem_q <= '0;
			qd_q  <= {nm, {FRAC_BITS{1'b0}}};
		end else if (busy) begin
			rem_q <= ge ? DATA_W'(rem_sh - {1'b0, dm_q}) : rem_sh[DATA_W-1:0];
			qd_q  <= {qd_q[DIV_W-2:0], ge};
		end
	end

	always_comb begin
		if (neg_q) begin
			if ((|qd_q[DIV_W-1:DATA_W]) || (qd_q[DATA_W-1] && (|qd_q[DATA_W-2:0])))
				quo = {1'b1, {(DATA_W-1){1'b0}}};
			else
				quo = -$signed(qd_q[DATA_W-1:0]);
		end else begin
			if (|qd_q[DIV_W-1:DATA_W-1])
				quo = {1'b0, {(DATA_W-1){1'b1}}};
			else
				quo = $signed(qd_q[DATA_W-1:0]);
		end
	end
endmodule

>>> sv/qrls_sqrt.sv
// floor integer square root, two radicand bits per cycle
module qrls_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [qrls_pkg::SQ_W-1:0]     radicand,
	output logic                          busy,
	output logic [qrls_pkg::DATA_W-1:0]   root
);
	import qrls_pkg::*;

	logic [ROOTC_W-1:0] cnt_q;
	logic [SQ_W-1:0]    x_q;
	logic [SQ_W-1:0]    res_q;
	logic [SQ_W-1:0]    bit_q;
	logic [SQ_W-1:0]    trial;

	assign trial = res_q + bit_q;
	assign busy  = cnt_q != '0;
	assign root  = res_q[DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= ROOTC_W'(ROOT_STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			res_q <= '0;
			bit_q <= {2'b01, {(SQ_W-2){1'b0}}};
		end else if (busy) begin
			if (x_q >= trial) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

>>> sv/qrls_dp.sv
// datapath: stores, multiply-accumulate pipeline, divider and square root
module qrls_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  qrls_pkg::cmd_t                      cmd,
	input  logic [qrls_pkg::POS_W-1:0]          ld_row,
	input  logic [qrls_pkg::POS_W-1:0]          ld_col,
	input  logic signed [qrls_pkg::DATA_W-1:0]  ld_value,
	output qrls_pkg::stat_t                     stat,
	output logic [qrls_pkg::POS_W-1:0]          x_index,
	output logic signed [qrls_pkg::DATA_W-1:0]  x_value,
	output logic                                singular,
	output logic                                last
);
	import qrls_pkg::*;

	logic signed [DATA_W-1:0] a_mem [MAX_ORDER*MAX_ORDER];
	logic signed [DATA_W-1:0] q_mem [MAX_ORDER*MAX_ORDER];
	logic signed [DATA_W-1:0] r_mem [MAX_ORDER*MAX_ORDER];
	logic signed [DATA_W-1:0] b_q [MAX_ORDER];
	logic signed [DATA_W-1:0] v_q [MAX_ORDER];
	logic signed [DATA_W-1:0] y_q [MAX_ORDER];
	logic signed [DATA_W-1:0] x_q [MAX_ORDER];
	logic signed [DATA_W-1:0] diag_q [MAX_ORDER];
	logic signed [DATA_W-1:0] a_rd_q, q_rd_q, r_rd_q, d_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [SQ_W-1:0]          ssq_q;
	logic                     sing_q;

	op_t                      op_s1, op_s2;
	logic [IDX_W-1:0]         idx_s1, idx_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [DATA_W-1:0] ld_s2;
	logic signed [DATA_W-1:0] opa, opb;
	logic signed [ACC_W-1:0]  psh;
	logic [SQ_W:0]            ssq_sum;

	logic                     div_start, div_busy, sqrt_busy;
	logic signed [DATA_W-1:0] div_num, quo;
	logic signed [DATA_W:0]   div_den;
	logic [DATA_W-1:0]        nrm;

	always_ff @(posedge clk) begin
		if (cmd.act == ACT_LD_A)
			a_mem[{ld_row, ld_col}] <= ld_value;
		a_rd_q <= a_mem[{cmd.idx, cmd.vec}];
	end

	always_ff @(posedge clk) begin
		if (cmd.act == ACT_WR_Q)
			q_mem[{cmd.vec, cmd.idx}] <= (nrm == '0) ? '0 : quo;
		q_rd_q <= q_mem[{cmd.vec, cmd.idx}];
	end

	always_ff @(posedge clk) begin
		if (cmd.act == ACT_WR_R)
			r_mem[{cmd.vec, cmd.idx}] <= sat_acc(acc_q);
		r_rd_q <= r_mem[{cmd.vec, cmd.idx}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
			op_s2 <= OP_NONE;
		end else begin
			op_s1 <= cmd.op;
			op_s2 <= op_s1;
		end
	end

	always_comb begin
		opa = q_rd_q;
		opb = v_q[idx_s1];
		unique case (op_s1)
			OP_DOT_QB: opb = b_q[idx_s1];
			OP_DOT_RX: begin
				opa = r_rd_q;
				opb = x_q[idx_s1];
			end
			OP_RES:    opb = d_q;
			OP_SQ:     opa = v_q[idx_s1];
			default:   ;
		endcase
	end

	always_ff @(posedge clk) begin
		idx_s1  <= cmd.idx;
		idx_s2  <= idx_s1;
		prod_s2 <= opa * opb;
		ld_s2   <= a_rd_q;
	end

	assign psh     = ACC_W'($signed(prod_s2[PROD_W-1:FRAC_BITS]));
	assign ssq_sum = {1'b0, ssq_q} + {1'b0, prod_s2};

	always_ff @(posedge clk) begin
		if (cmd.act == ACT_LD_B)
			b_q[ld_row] <= ld_value;
		if (cmd.act == ACT_LATCH_D)
			d_q <= sat_acc(acc_q);
		if (cmd.act == ACT_WR_R && cmd.vec == cmd.idx)
			diag_q[cmd.idx] <= sat_acc(acc_q);
		if (cmd.act == ACT_WR_Y)
			y_q[cmd.idx] <= sat_acc(acc_q);
		if (cmd.act == ACT_WR_X)
			x_q[cmd.idx] <= (diag_q[cmd.idx] == '0) ? '0 : quo;
		if (op_s2 == OP_LDV)
			v_q[idx_s2] <= ld_s2;
		else if (op_s2 == OP_RES)
			v_q[idx_s2] <= sat_acc(ACC_W'(v_q[idx_s2]) - psh);
		if (cmd.act == ACT_CLR) begin
			acc_q <= '0;
			ssq_q <= '0;
		end else if (op_s2 == OP_DOT_QV || op_s2 == OP_DOT_QB || op_s2 == OP_DOT_RX) begin
			acc_q <= acc_q + psh;
		end else if (op_s2 == OP_SQ) begin
			ssq_q <= ssq_sum[SQ_W] ? {SQ_W{1'b1}} : ssq_sum[SQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sing_q <= 1'b0;
		end else if (cmd.act == ACT_START) begin
			sing_q <= 1'b0;
		end else if (cmd.act == ACT_WR_Q && nrm == '0) begin
			sing_q <= 1'b1;
		end else if (cmd.act == ACT_WR_X && diag_q[cmd.idx] == '0) begin
			sing_q <= 1'b1;
		end
	end

	assign div_start = (cmd.act == ACT_DIV_Q) || (cmd.act == ACT_DIV_X);
	assign div_num   = (cmd.act == ACT_DIV_Q) ? v_q[cmd.idx]
	                   : sat_acc(ACC_W'(y_q[cmd.idx]) - acc_q);
	assign div_den   = (cmd.act == ACT_DIV_Q) ? $signed({1'b0, nrm})
	                   : (DATA_W+1)'(diag_q[cmd.idx]);

	qrls_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (quo)
	);

	qrls_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.act == ACT_SQRT),
		.radicand (ssq_q),
		.busy     (sqrt_busy),
		.root     (nrm)
	);

	assign stat.sqrt_busy = sqrt_busy;
	assign stat.div_busy  = div_busy;
	assign x_index  = POS_W'(cmd.idx);
	assign x_value  = sing_q ? '0 : x_q[cmd.idx];
	assign singular = sing_q;
	assign last     = cmd.last;
endmodule

>>> sv/qrls_ctrl.sv
// controller: order register and solve sequencer
module qrls_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [qrls_pkg::ORD_W-1:0]      cfg_wdata,
	input  logic                            req_valid,
	input  logic [qrls_pkg::REQ_W-1:0]      req_type,
	output logic                            req_ready,
	output logic                            res_valid,
	input  logic                            res_ready,
	input  qrls_pkg::stat_t                 stat,
	output qrls_pkg::cmd_t                  cmd
);
	import qrls_pkg::*;

	state_t           state_q, state_d, ret_q, ret_d;
	logic             drn_q, drn_d;
	logic [CNT_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
	logic [ORD_W-1:0] order_q;
	logic [CNT_W-1:0] n_eff, nm1;
	logic             last_i;

	assign n_eff  = (order_q == '0) ? CNT_W'(1)
	                : (order_q > ORD_W'(MAX_ORDER)) ? CNT_W'(MAX_ORDER) : CNT_W'(order_q);
	assign nm1    = n_eff - 1'b1;
	assign last_i = i_q == nm1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			drn_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			order_q <= ORD_W'(ORDER_RESET);
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			drn_q   <= drn_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			if (cfg_we)
				order_q <= cfg_wdata;
		end
	end

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		drn_d     = 1'b0;
		i_d       = i_q;
		j_d       = j_q;
		k_d       = k_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		cmd.op    = OP_NONE;
		cmd.act   = ACT_NONE;
		cmd.vec   = j_q[IDX_W-1:0];
		cmd.idx   = i_q[IDX_W-1:0];
		cmd.last  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (req_type)
						REQ_WR_A: cmd.act = ACT_LD_A;
						REQ_WR_B: cmd.act = ACT_LD_B;
						REQ_SOLVE: begin
							cmd.act = ACT_START;
							i_d     = '0;
							j_d     = '0;
							state_d = ST_GS_LD;
						end
						default: ;
					endcase
				end
			end
			ST_DRAIN: begin
				drn_d = !drn_q;
				if (drn_q)
					state_d = ret_q;
			end
			ST_GS_LD: begin
				cmd.op = OP_LDV;
				i_d    = i_q + 1'b1;
				if (last_i) begin
					i_d     = '0;
					k_d     = '0;
					ret_d   = ST_GS_KCHK;
					state_d = ST_DRAIN;
				end
			end
			ST_GS_KCHK: begin
				cmd.act = ACT_CLR;
				i_d     = '0;
				state_d = (k_q < j_q) ? ST_GS_DOT : ST_GS_SQ;
			end
			ST_GS_DOT: begin
				cmd.op  = OP_DOT_QV;
				cmd.vec = k_q[IDX_W-1:0];
				i_d     = i_q + 1'b1;
				if (last_i) begin
					i_d     = '0;
					ret_d   = ST_GS_D;
					state_d = ST_DRAIN;
				end
			end
			ST_GS_D: begin
				cmd.act = ACT_LATCH_D;
				state_d = ST_GS_RES;
			end
			ST_GS_RES: begin
				cmd.op  = OP_RES;
				cmd.vec = k_q[IDX_W-1:0];
				i_d     = i_q + 1'b1;
				if (last_i) begin
					i_d     = '0;
					k_d     = k_q + 1'b1;
					ret_d   = ST_GS_KCHK;
					state_d = ST_DRAIN;
				end
			end
			ST_GS_SQ: begin
				cmd.op = OP_SQ;
				i_d    = i_q + 1'b1;
				if (last_i) begin
					i_d     = '0;
					ret_d   = ST_GS_SQRT;
					state_d = ST_DRAIN;
				end
			end
			ST_GS_SQRT: begin
				cmd.act = ACT_SQRT;
				state_d = ST_GS_SQW;
			end
			ST_GS_SQW: begin
				if (!stat.sqrt_busy)
					state_d = ST_GS_DIV;
			end
			ST_GS_DIV: begin
				cmd.act = ACT_DIV_Q;
				state_d = ST_GS_DIVW;
			end
			ST_GS_DIVW: begin
				if (!stat.div_busy)
					state_d = ST_GS_WQ;
			end
			ST_GS_WQ: begin
				cmd.act = ACT_WR_Q;
				i_d     = i_q + 1'b1;
				state_d = ST_GS_DIV;
				if (last_i) begin
					i_d = '0;
					if (j_q == nm1) begin
						j_d     = '0;
						state_d = ST_R_LD;
					end else begin
						j_d     = j_q + 1'b1;
						state_d = ST_GS_LD;
					end
				end
			end
			ST_R_LD: begin
				cmd.op = OP_LDV;
				i_d    = i_q + 1'b1;
				if (last_i) begin
					i_d     = '0;
					k_d     = '0;
					ret_d   = ST_R_ROW;
					state_d = ST_DRAIN;
				end
			end
			ST_R_ROW: begin
				cmd.act = ACT_CLR;
				state_d = ST_R_DOT;
			end
			ST_R_DOT: begin
				cmd.op  = OP_DOT_QV;
				cmd.vec = k_q[IDX_W-1:0];
				i_d     = i_q + 1'b1;
				if (last_i) begin
					i_d     = '0;
					ret_d   = ST_R_WR;
					state_d = ST_DRAIN;
				end
			end
			ST_R_WR: begin
				cmd.act = ACT_WR_R;
				cmd.vec = k_q[IDX_W-1:0];
				cmd.idx = j_q[IDX_W-1:0];
				if (k_q == j_q) begin
					k_d = '0;
					if (j_q == nm1) begin
						state_d = ST_Y_ROW;
					end else begin
						j_d     = j_q + 1'b1;
						state_d = ST_R_LD;
					end
				end else begin
					k_d     = k_q + 1'b1;
					state_d = ST_R_ROW;
				end
			end
			ST_Y_ROW: begin
				cmd.act = ACT_CLR;
				state_d = ST_Y_DOT;
			end
			ST_Y_DOT: begin
				cmd.op  = OP_DOT_QB;
				cmd.vec = k_q[IDX_W-1:0];
				i_d     = i_q + 1'b1;
				if (last_i) begin
					i_d     = '0;
					ret_d   = ST_Y_WR;
					state_d = ST_DRAIN;
				end
			end
			ST_Y_WR: begin
				cmd.act = ACT_WR_Y;
				cmd.idx = k_q[IDX_W-1:0];
				if (k_q == nm1) begin
					state_d = ST_B_ROW;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = ST_Y_ROW;
				end
			end
			ST_B_ROW: begin
				cmd.act = ACT_CLR;
				if (k_q == nm1) begin
					state_d = ST_B_DIV;
				end else begin
					i_d     = k_q + 1'b1;
					state_d = ST_B_DOT;
				end
			end
			ST_B_DOT: begin
				cmd.op  = OP_DOT_RX;
				cmd.vec = k_q[IDX_W-1:0];
				i_d     = i_q + 1'b1;
				if (last_i) begin
					i_d     = '0;
					ret_d   = ST_B_DIV;
					state_d = ST_DRAIN;
				end
			end
			ST_B_DIV: begin
				cmd.act = ACT_DIV_X;
				cmd.idx = k_q[IDX_W-1:0];
				state_d = ST_B_DIVW;
			end
			ST_B_DIVW: begin
				cmd.idx = k_q[IDX_W-1:0];
				if (!stat.div_busy)
					state_d = ST_B_WX;
			end
			ST_B_WX: begin
				cmd.act = ACT_WR_X;
				cmd.idx = k_q[IDX_W-1:0];
				if (k_q == '0) begin
					i_d     = '0;
					state_d = ST_OUT;
				end else begin
					k_d     = k_q - 1'b1;
					state_d = ST_B_ROW;
				end
			end
			ST_OUT: begin
				res_valid = 1'b1;
				cmd.last  = last_i;
				if (res_ready) begin
					if (last_i) begin
						i_d     = '0;
						state_d = ST_IDLE;
					end else begin
						i_d = i_q + 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

>>> sv/qr_linear_solver_top.sv
// top level of the QR linear solver
// Solves A x = b of order n (1..8, from the order register) in signed Q16.16.
// Write requests for A and b are taken one per cycle. A solve request holds the
// block until its n results have all been taken; it runs Gram-Schmidt, forms R
// and Q^T b, and back-substitutes, all through one multiply-accumulate pipeline
// (each dot product followed by a drain), a 32-step square root per column and
// a restoring divider used n(n+1) times; results then leave one per cycle while
// the sink is ready.
module qr_linear_solver_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [qrls_pkg::ORD_W-1:0]    cfg_wdata,
	qrls_req_if.sink                      req,
	qrls_res_if.source                    res
);
	import qrls_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	qrls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	qrls_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.ld_row   (req.row),
		.ld_col   (req.col),
		.ld_value (req.value),
		.stat     (stat),
		.x_index  (res.x_index),
		.x_value  (res.x_value),
		.singular (res.singular),
		.last     (res.last)
	);
endmodule

>>> tb/qr_linear_solver_top_tb.sv
// self-checking testbench of the QR linear solver top level
`timescale 1ns / 1ps

module qr_linear_solver_top_tb;
	import qrls_pkg::*;

	typedef struct packed {
		logic [REQ_W-1:0]         req_type;
		logic [POS_W-1:0]         row;
		logic [POS_W-1:0]         col;
		logic signed [DATA_W-1:0] value;
	} request_t;

	typedef struct packed {
		logic [POS_W-1:0]         x_index;
		logic signed [DATA_W-1:0] x_value;
		logic                     singular;
		logic                     last;
	} solution_t;

	localparam int IDLE_LIMIT = 20000;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ORD_W-1:0] cfg_wdata;

	qrls_req_if req_ch();
	qrls_res_if res_ch();

	qr_linear_solver_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch.sink),
		.res(res_ch.source)
	);

	request_t  pending_reqs[$];
	solution_t expected_x[$];
	int        error_count = 0;
	int        idle_cycles = 0;
	int        gap_left = 0;
	int        burst_left = 0;
	int        stall_phase = 0;
	bit        stim_done = 0;
	bit        req_taken = 0;

	// predictor state
	logic [ORD_W-1:0]         order_reg;
	logic signed [DATA_W-1:0] a_mat[MAX_ORDER][MAX_ORDER];
	logic signed [DATA_W-1:0] b_vec[MAX_ORDER];
	logic signed [DATA_W-1:0] q_col[MAX_ORDER][MAX_ORDER];
	logic signed [DATA_W-1:0] r_mat[MAX_ORDER][MAX_ORDER];
	logic signed [DATA_W-1:0] x_vec[MAX_ORDER];

	function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'sh7fffffff;
		if (v < -128'sd2147483648) return 32'sh80000000;
		return v[DATA_W-1:0];
	endfunction

	function automatic logic signed [127:0] fx_mul(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		logic signed [127:0] p;
		p = 128'(a) * 128'(b);
		return p >>> FRAC_BITS;
	endfunction

	function automatic logic signed [DATA_W-1:0] fx_div(input logic signed [DATA_W-1:0] num,
			input logic signed [127:0] den);
		logic [127:0] nm, dm, q;
		logic neg;
		neg = (num < 0) != (den < 0);
		nm = num < 0 ? 128'(-128'(num)) : 128'(num);
		dm = den < 0 ? 128'(-den) : 128'(den);
		q = (nm << FRAC_BITS) / dm;
		if (neg) return clamp32(-$signed(q));
		return clamp32($signed(q));
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
		logic [63:0] r, bt;
		r = 0;
		bt = 64'd1 << 62;
		while (bt > x) bt >>= 2;
		while (bt != 0) begin
			if (x >= r + bt) begin
				x -= r + bt;
				r = (r >> 1) + bt;
			end else begin
				r >>= 1;
			end
			bt >>= 2;
		end
		return r;
	endfunction

	task automatic solve_system();
		logic signed [DATA_W-1:0] v[MAX_ORDER];
		logic signed [DATA_W-1:0] y[MAX_ORDER];
		logic signed [127:0] s;
		logic [127:0] sumsq;
		logic [63:0] nrm;
		logic sing;
		logic signed [DATA_W-1:0] d, numr;
		int n;
		n = order_reg == 0 ? 1 : (order_reg > MAX_ORDER ? MAX_ORDER : int'(order_reg));
		sing = 0;
		for (int j = 0; j < n; j++) begin
			for (int i = 0; i < n; i++) v[i] = a_mat[i][j];
			for (int k = 0; k < j; k++) begin
				s = 0;
				for (int i = 0; i < n; i++) s += fx_mul(q_col[k][i], v[i]);
				d = clamp32(s);
				for (int i = 0; i < n; i++) v[i] = clamp32(128'(v[i]) - fx_mul(q_col[k][i], d));
			end
			sumsq = 0;
			for (int i = 0; i < n; i++) sumsq += 128'(128'(v[i]) * 128'(v[i]));
			if (sumsq > 128'hffff_ffff_ffff_ffff) sumsq = 128'hffff_ffff_ffff_ffff;
			nrm = floor_sqrt(sumsq[63:0]);
			for (int i = 0; i < n; i++)
				q_col[j][i] = nrm == 0 ? '0 : fx_div(v[i], $signed({64'd0, nrm}));
			if (nrm == 0) sing = 1;
		end
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) begin
				s = 0;
				for (int k = 0; k < n; k++) s += fx_mul(q_col[j][k], a_mat[k][i]);
				r_mat[j][i] = j <= i ? clamp32(s) : '0;
			end
		for (int i = 0; i < n; i++) begin
			s = 0;
			for (int k = 0; k < n; k++) s += fx_mul(q_col[i][k], b_vec[k]);
			y[i] = clamp32(s);
		end
		for (int i = n - 1; i >= 0; i--) begin
			s = 0;
			for (int k = i + 1; k < n; k++) s += fx_mul(r_mat[i][k], x_vec[k]);
			numr = clamp32(128'(y[i]) - s);
			if (r_mat[i][i] == 0) begin
				sing = 1;
				x_vec[i] = 0;
			end else begin
				x_vec[i] = fx_div(numr, 128'(r_mat[i][i]));
			end
		end
		for (int i = 0; i < n; i++)
			expected_x.push_back('{x_index: POS_W'(i), x_value: sing ? '0 : x_vec[i],
				singular: sing, last: i == n - 1});
	endtask

	task automatic apply_request(input request_t r);
		case (r.req_type)
			REQ_WR_A: a_mat[r.row][r.col] = r.value;
			REQ_WR_B: b_vec[r.row] = r.value;
			REQ_SOLVE: solve_system();
			default: ;
		endcase
	endtask

	function automatic logic signed [DATA_W-1:0] rand_value(input int shape);
		case (shape)
			0: return $signed($urandom());
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			3: return 0;
			default: return $signed(32'($urandom_range(0, 'h7ffff)) - 32'h40000);
		endcase
	endfunction

	function automatic request_t mk_req(input logic [REQ_W-1:0] t, input int r, input int c,
			input logic signed [DATA_W-1:0] v);
		return '{req_type: t, row: POS_W'(r), col: POS_W'(c), value: v};
	endfunction

	task automatic queue_system(input int shape, input bit diag_boost);
		logic signed [DATA_W-1:0] v;
		for (int r = 0; r < MAX_ORDER; r++) begin
			for (int c = 0; c < MAX_ORDER; c++) begin
				v = rand_value($urandom_range(0, 9) == 0 ? shape : 4);
				if (diag_boost && r == c) v = v + 32'sh00080000;
				pending_reqs.push_back(mk_req(REQ_WR_A, r, c, v));
			end
			pending_reqs.push_back(mk_req(REQ_WR_B, r, 0, rand_value($urandom_range(0, 4))));
		end
	endtask

	task automatic run_queued();
		wait (pending_reqs.size() == 0 && !req_ch.valid);
		wait (expected_x.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_order(input logic [ORD_W-1:0] o);
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= o;
		@(negedge clk);
		cfg_we <= 0;
		order_reg = o;
	endtask

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// request accepted at the last rising edge
	always @(posedge clk) begin
		req_taken <= arst_n && req_ch.valid && req_ch.ready;
	end

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 0;
		end else if (req_ch.valid && !req_taken) begin
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			req_ch.valid <= 0;
		end else if (pending_reqs.size() > 0) begin
			request_t r;
			r = pending_reqs.pop_front();
			{req_ch.req_type, req_ch.row, req_ch.col, req_ch.value} <= r;
			req_ch.valid <= 1;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 20);
				gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			req_ch.valid <= 0;
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		if (!arst_n) res_ch.ready <= 0;
		else if ((stall_phase / 300) % 3 == 0) res_ch.ready <= 1;
		else res_ch.ready <= $urandom_range(0, 2) != 0;
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				apply_request({req_ch.req_type, req_ch.row, req_ch.col, req_ch.value});
			if (res_ch.valid && res_ch.ready) begin
				solution_t e;
				if (expected_x.size() == 0) begin
					$error("result with no expectation, x_index %0d", res_ch.x_index);
					error_count++;
				end else begin
					e = expected_x.pop_front();
					if (res_ch.x_index !== e.x_index) begin
						$error("x_index exp %0d got %0d", e.x_index, res_ch.x_index);
						error_count++;
					end
					if (res_ch.x_value !== e.x_value) begin
						$error("x_value exp %0d got %0d", e.x_value, res_ch.x_value);
						error_count++;
					end
					if (res_ch.singular !== e.singular) begin
						$error("singular exp %0d got %0d", e.singular, res_ch.singular);
						error_count++;
					end
					if (res_ch.last !== e.last) begin
						$error("last exp %0d got %0d", e.last, res_ch.last);
						error_count++;
					end
				end
			end
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("qr_linear_solver_top: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int shape;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		req_ch.valid = 0;
		req_ch.req_type = REQ_WR_A;
		req_ch.row = '0;
		req_ch.col = '0;
		req_ch.value = '0;
		res_ch.ready = 0;
		order_reg = ORDER_RESET;
		for (int i = 0; i < MAX_ORDER; i++) begin
			b_vec[i] = 0;
			x_vec[i] = 0;
			for (int j = 0; j < MAX_ORDER; j++) begin
				a_mat[i][j] = 0;
				q_col[i][j] = 0;
				r_mat[i][j] = 0;
			end
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: identity system at reset order, extremes, unused request, singular
		for (int r = 0; r < MAX_ORDER; r++) begin
			for (int c = 0; c < MAX_ORDER; c++)
				pending_reqs.push_back(mk_req(REQ_WR_A, r, c, r == c ? 32'sh00010000 : 0));
			pending_reqs.push_back(mk_req(REQ_WR_B, r, 0, r[0] ? 32'sh80000000 : 32'sh7fffffff));
		end
		pending_reqs.push_back(mk_req(REQ_UNUSED, 7, 7, 32'sh7fffffff));
		pending_reqs.push_back(mk_req(REQ_SOLVE, 0, 0, 0));
		pending_reqs.push_back(mk_req(REQ_WR_A, 3, 3, 0));
		pending_reqs.push_back(mk_req(REQ_SOLVE, 7, 7, 32'shffffffff));
		run_queued();
		set_order(0);
		pending_reqs.push_back(mk_req(REQ_WR_A, 0, 0, 32'sh7fffffff));
		pending_reqs.push_back(mk_req(REQ_SOLVE, 0, 0, 0));
		pending_reqs.push_back(mk_req(REQ_WR_A, 0, 0, 32'sh80000000));
		pending_reqs.push_back(mk_req(REQ_SOLVE, 0, 0, 0));
		run_queued();
		set_order(4'd15);
		pending_reqs.push_back(mk_req(REQ_WR_A, 3, 3, 32'sh00010000));
		pending_reqs.push_back(mk_req(REQ_SOLVE, 0, 0, 0));
		run_queued();

		// random phases over several orders, counting the directed requests
		sent = 82;
		while (sent < 420) begin
			set_order(ORD_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
				: $urandom_range(1, 3)));
			shape = $urandom_range(0, 3);
			queue_system(shape, $urandom_range(0, 3) != 0);
			sent += 72;
			for (int s = 0; s < 3; s++) begin
				repeat ($urandom_range(0, 6)) begin
					logic [REQ_W-1:0] t;
					t = $urandom_range(0, 3) == 0 ? REQ_UNUSED
						: ($urandom_range(0, 1) ? REQ_WR_A : REQ_WR_B);
					if (t == REQ_UNUSED) t = REQ_UNUSED;
					pending_reqs.push_back(mk_req(t == REQ_UNUSED ? REQ_UNUSED : t,
						$urandom_range(0, 7), $urandom_range(0, 7),
						rand_value($urandom_range(0, 4))));
					sent++;
				end
				pending_reqs.push_back(mk_req(REQ_SOLVE, $urandom_range(0, 7),
					$urandom_range(0, 7), $signed($urandom())));
				sent++;
			end
			run_queued();
		end
		stim_done = 1;
		repeat (100) @(posedge clk);
		if (error_count == 0 && expected_x.size() == 0) begin
			$display("qr_linear_solver_top: match");
		end else begin
			$display("qr_linear_solver_top: mismatch");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/qrls_pkg.sv
sv/qrls_if.sv
sv/qrls_div.sv
sv/qrls_sqrt.sv
sv/qrls_dp.sv
sv/qrls_ctrl.sv
sv/qr_linear_solver_top.sv
tb/qr_linear_solver_top_tb.sv
